/* hdl/twm_pkg.sv */
// Package for the topic wildcard matcher.
// Holds the request command codes, character constants and the walker status struct.
// No dependencies.
package twm_pkg;

	localparam int CHAR_W = 8;

	typedef logic [CHAR_W-1:0] char_t;

	// request command codes
	localparam logic [1:0] CMD_TOPIC  = 2'd0;
	localparam logic [1:0] CMD_FILTER = 2'd1;
	localparam logic [1:0] CMD_EVAL   = 2'd2;

	localparam char_t CHAR_NUL   = 8'h00;
	localparam char_t CHAR_PLUS  = 8'h2B;
	localparam char_t CHAR_HASH  = 8'h23;
	localparam char_t CHAR_SLASH = 8'h2F;

	typedef struct packed {
		logic busy;
		logic done;
		logic match;
	} walk_status_t;

endpackage

/* hdl/twm_char_mem.sv */
// Character buffer: one write port, one read port, read data registered.
// Depends on twm_pkg.
module twm_char_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  twm_pkg::char_t    wdata,
	input  logic [AW-1:0]     raddr,
	output twm_pkg::char_t    rdata
);

	twm_pkg::char_t mem [DEPTH];
	twm_pkg::char_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/twm_walker.sv */
// Match walker: steps through topic and filter buffers, one character step a cycle.
// Depends on twm_pkg; drives the read addresses of both twm_char_mem instances.
module twm_walker #(
	parameter int MAX_LEN = 64,
	parameter int CW      = 7,
	parameter int AW      = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  ack,
	input  logic [CW-1:0]         tcnt,
	input  logic [CW-1:0]         fcnt,
	input  twm_pkg::char_t        t_rdata,
	input  twm_pkg::char_t        f_rdata,
	output logic [AW-1:0]         t_addr,
	output logic [AW-1:0]         f_addr,
	output twm_pkg::walk_status_t status
);

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_t;

	state_t        state_q;
	logic [CW-1:0] i_q, j_q, i_d, j_d;
	logic          skip_q, skip_d;
	logic          match_q;
	logic          fin, res;
	logic          t_end, f_end, j_last, bad_len;

	assign t_end   = (i_q >= tcnt);
	assign f_end   = (j_q >= fcnt);
	assign j_last  = ((j_q + CW'(1)) >= fcnt);
	assign bad_len = (tcnt == '0) || (fcnt == '0) ||
	                 (tcnt >= CW'(MAX_LEN)) || (fcnt >= CW'(MAX_LEN));

	always_comb begin
		i_d    = i_q;
		j_d    = j_q;
		skip_d = skip_q;
		fin    = 1'b0;
		res    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				i_d    = '0;
				j_d    = '0;
				skip_d = 1'b0;
			end
			ST_WALK: begin
				if (t_end && f_end) begin
					fin = 1'b1;
					res = 1'b1;
				end else if (!skip_q && !t_end &&
				             (t_rdata == twm_pkg::CHAR_PLUS ||
				              t_rdata == twm_pkg::CHAR_HASH)) begin
					fin = 1'b1;
				end else if (!f_end && f_rdata == twm_pkg::CHAR_HASH) begin
					fin = 1'b1;
					res = j_last;
				end else if (!f_end && f_rdata == twm_pkg::CHAR_PLUS) begin
					// level skip; wildcards in the topic pass unchecked here
					if (t_end) begin
						fin = 1'b1;
						res = 1'b1;
					end else if (t_rdata == twm_pkg::CHAR_SLASH) begin
						j_d    = j_q + CW'(1);
						skip_d = 1'b0;
					end else begin
						i_d    = i_q + CW'(1);
						skip_d = 1'b1;
					end
				end else if (t_end || f_end || t_rdata != f_rdata) begin
					fin = 1'b1;
				end else begin
					i_d = i_q + CW'(1);
					j_d = j_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

	// next index goes straight to the memories so data lines up with the step
	assign t_addr = i_d[AW-1:0];
	assign f_addr = j_d[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			skip_q  <= 1'b0;
			match_q <= 1'b0;
		end else begin
			i_q    <= i_d;
			j_q    <= j_d;
			skip_q <= skip_d;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (bad_len) begin
							match_q <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (fin) begin
						match_q <= res;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign status.busy  = (state_q != ST_IDLE);
	assign status.done  = (state_q == ST_DONE);
	assign status.match = match_q;

`ifndef SYNTHESIS
	a_i_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> i_q <= tcnt)
		else $error("topic index past count");
	a_j_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> j_q <= fcnt)
		else $error("filter index past count");
	a_skip_on_plus: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && skip_q) |-> (j_q < fcnt && f_rdata == twm_pkg::CHAR_PLUS))
		else $error("level skip without plus in filter");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> (i_q == '0 && j_q == '0))
		else $error("walk did not start at the heads");
`endif

endmodule

/* hdl/topic_wildcard_matcher_unit.sv */
// Topic wildcard matcher: request channel with cmd/char_in, response channel with match.
// A cmd of 0 appends char_in to the topic buffer, 1 appends it to the filter buffer,
// 2 evaluates the filter against the topic, returns one match response and empties both.
// Appends produce no response; a zero byte, cmd 3, and characters beyond MAX_LEN are
// dropped. Either string empty or full at evaluate gives match 0.
// Evaluate: the walker takes one character step per cycle, bounded by the single read
// port of each buffer; after the last step it enters its done state, and the response
// is loaded from there into the output register once that register is free (an empty or
// full string skips the walk and goes straight to the done state).
// req_stall is high from an accepted evaluate until its response is loaded into the
// output register.
// The output register holds the response while rsp_stall is high; appends are still
// accepted in that time, a following evaluate walks and then keeps req_stall high until
// the register is free.
// Reset clears the lengths and the walker; buffer contents are not cleared.
// Depends on twm_pkg, twm_char_mem and twm_walker.
module topic_wildcard_matcher_unit #(
	parameter int MAX_LEN = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [1:0]             cmd,
	input  logic [7:0]             char_in,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic                   match
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	logic [CW-1:0]         topic_count_q, filter_count_q;
	logic                  rsp_valid_q, match_q;
	logic                  req_fire, t_we, f_we, start, ack;
	logic [AW-1:0]         t_raddr, f_raddr;
	twm_pkg::char_t        t_rdata, f_rdata;
	twm_pkg::walk_status_t status;

	assign req_fire = req_valid && !req_stall;
	assign t_we  = req_fire && (cmd == twm_pkg::CMD_TOPIC) &&
	               (char_in != twm_pkg::CHAR_NUL) && (topic_count_q < CW'(MAX_LEN));
	assign f_we  = req_fire && (cmd == twm_pkg::CMD_FILTER) &&
	               (char_in != twm_pkg::CHAR_NUL) && (filter_count_q < CW'(MAX_LEN));
	assign start = req_fire && (cmd == twm_pkg::CMD_EVAL);
	assign ack   = status.done && (!rsp_valid_q || !rsp_stall);

	assign req_stall = status.busy;

	twm_char_mem #(.DEPTH(MAX_LEN), .AW(AW)) u_topic_mem (
		.clk   (clk),
		.we    (t_we),
		.waddr (topic_count_q[AW-1:0]),
		.wdata (char_in),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	twm_char_mem #(.DEPTH(MAX_LEN), .AW(AW)) u_filter_mem (
		.clk   (clk),
		.we    (f_we),
		.waddr (filter_count_q[AW-1:0]),
		.wdata (char_in),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	twm_walker #(.MAX_LEN(MAX_LEN), .CW(CW), .AW(AW)) u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.ack     (ack),
		.tcnt    (topic_count_q),
		.fcnt    (filter_count_q),
		.t_rdata (t_rdata),
		.f_rdata (f_rdata),
		.t_addr  (t_raddr),
		.f_addr  (f_raddr),
		.status  (status)
	);

	// lengths are cleared once the response is taken into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topic_count_q  <= '0;
			filter_count_q <= '0;
		end else if (ack) begin
			topic_count_q  <= '0;
			filter_count_q <= '0;
		end else begin
			if (t_we) begin
				topic_count_q <= topic_count_q + CW'(1);
			end
			if (f_we) begin
				filter_count_q <= filter_count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			match_q     <= 1'b0;
		end else if (ack) begin
			rsp_valid_q <= 1'b1;
			match_q     <= status.match;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign match     = match_q;

`ifndef SYNTHESIS
	a_clear_on_ack: assert property (@(posedge clk) disable iff (!arst_n)
		ack |=> (topic_count_q == '0 && filter_count_q == '0))
		else $error("lengths not cleared after evaluate");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> !(t_we || f_we))
		else $error("buffer written during a walk");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(match)))
		else $error("stalled response changed");
`endif

endmodule
